[src/bmp24_stream_to_framebuffer_assert.svh]
// Assertion macros for the BMP-to-framebuffer RTL.
// Included by the top level; depends on nothing else.
`ifndef BMP24_STREAM_TO_FRAMEBUFFER_ASSERT_SVH
`define BMP24_STREAM_TO_FRAMEBUFFER_ASSERT_SVH

// Checks that the consequent holds in every cycle where the antecedent holds.
`define BMP24FB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmp24fb: implication violated");

// Checks that a condition never occurs.
`define BMP24FB_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bmp24fb: forbidden condition seen");

`endif

[src/bmp24fb_pkg.sv]
// Shared types, constants and helper functions of the BMP-to-framebuffer block.
// No dependencies; imported by every module of the block.
`default_nettype none

package bmp24fb_pkg;

    // Field widths.
    localparam int SIDE_W   = 12;   // image width, height and pixel counters
    localparam int XOFF_W   = 10;
    localparam int YOFF_W   = 9;
    localparam int STEP_W   = 3;
    localparam int COORD_W  = 13;   // screen row or column before clipping
    localparam int ADDR_W   = 19;
    localparam int PIXEL_W  = 24;
    localparam int CIDX_W   = 3;

    // Register indexes of the configuration port.
    localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CIDX_W-1:0] REG_X_OFFSET     = 3'd2;
    localparam logic [CIDX_W-1:0] REG_Y_OFFSET     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_REDUCE_STEP  = 3'd4;

    // Register values after reset.
    localparam int RST_IMAGE_WIDTH  = 800;
    localparam int RST_IMAGE_HEIGHT = 480;
    localparam int RST_X_OFFSET     = 0;
    localparam int RST_Y_OFFSET     = 0;
    localparam int RST_REDUCE_STEP  = 1;

    // Decimation step limits.
    localparam logic [STEP_W-1:0] STEP_MIN = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MAX = 3'd4;

    // Floor division by three: (x * 2731) >> 13 is exact for x below 4096.
    localparam int DIV3_MUL   = 2731;
    localparam int DIV3_SHIFT = 13;

    // Cycles from a register write until the restart values are loaded.
    localparam logic [2:0] PEND_CYCLES = 3'd5;

    // Position of a byte within its pixel.
    typedef enum logic [1:0] {
        BP_BLUE,
        BP_GREEN,
        BP_RED
    } byte_phase_t;

    // Effective configuration and restart values handed to the pixel walker.
    typedef struct packed {
        logic                busy;          // restart values still settling
        logic                restart;       // reload walker state this cycle
        logic [SIDE_W-1:0]   width;         // clamped image width
        logic [STEP_W-1:0]   step;          // clamped decimation step
        logic [XOFF_W-1:0]   x_offset;
        logic [SIDE_W-1:0]   init_row_count;
        logic [1:0]          init_row_phase;
        logic [COORD_W-1:0]  init_screen_row;
        logic [ADDR_W-1:0]   init_row_base;
    } bmp24fb_cfg_t;

    // One result transaction.
    typedef struct packed {
        logic                write_enable;
        logic [ADDR_W-1:0]   write_address;
        logic [PIXEL_W-1:0]  pixel_word;
        logic                image_done;
    } bmp24fb_result_t;

    // Elaboration-time side clamp: zero acts as one, large values as the limit.
    function automatic int side_clamp(input int v, input int max_side);
        int r;
        r = v;
        if (r == 0) r = 1;
        if (r > max_side) r = max_side;
        return r;
    endfunction

endpackage

`default_nettype wire

[src/bmp24_stream_to_framebuffer.sv]
// A pixel's result is registered and seen by the master in the cycle after its red byte.
// Throughput: one byte per cycle; a result byte stalls while a result waits for the master.
// A register write also stalls the input while restart values settle.
// Reset (rst_n low, asynchronous) loads 800x480, offset 0/0, step 1, and an empty output.
// Depends on bmp24fb_pkg, bmp24fb_cfg, bmp24fb_walker, bmp24fb_out_reg and the assert header.
`default_nettype none

`include "bmp24_stream_to_framebuffer_assert.svh"

module bmp24_stream_to_framebuffer #(
    parameter int SCREEN_WIDTH   = 800,
    parameter int SCREEN_HEIGHT  = 480,
    parameter int MAX_IMAGE_SIDE = 4095
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Slave side: pixel-data bytes in file order.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,    // [7:0] data_byte
    // Master side: framebuffer writes.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata,    // [18:0] write_address, [42:19] pixel_word, rest 0
    output logic              m_tuser,    // [0] write_enable
    output logic              m_tlast,    // image_done
    // Configuration write port.
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [11:0]  cfg_wdata
);
    import bmp24fb_pkg::*;

    localparam int ADDR_LIMIT = (SCREEN_WIDTH * SCREEN_HEIGHT > (1 << ADDR_W)) ?
                                (1 << ADDR_W) : SCREEN_WIDTH * SCREEN_HEIGHT;

    bmp24fb_cfg_t    cfg;
    bmp24fb_result_t result;
    bmp24fb_result_t held;
    logic            will_emit;
    logic            out_space;
    logic            accept;
    logic            emit;
    logic            addr_in_range;

    // Input handshake: stall while restart values settle or a result byte meets a full slot.
    assign s_tready = !cfg.busy && (!will_emit || out_space);
    assign accept   = s_tvalid && s_tready;
    assign emit     = accept && will_emit;

    bmp24fb_cfg #(
        .SCREEN_WIDTH   (SCREEN_WIDTH),
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bmp24fb_walker #(
        .SCREEN_WIDTH   (SCREEN_WIDTH),
        .SCREEN_HEIGHT  (SCREEN_HEIGHT),
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .data_byte (s_tdata),
        .will_emit (will_emit),
        .result    (result)
    );

    bmp24fb_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (emit),
        .result   (result),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .space    (out_space),
        .held     (held)
    );

    // Pack the held result onto the master side.
    assign m_tdata = {5'b0, held.pixel_word, held.write_address};
    assign m_tuser = held.write_enable;
    assign m_tlast = held.image_done;

    // The held address lies inside the framebuffer.
    assign addr_in_range = (32'(held.write_address) < 32'(ADDR_LIMIT));

    // No byte is taken while restart values are still settling.
    `BMP24FB_ASSERT_NEVER(a_no_accept_busy, clk, rst_n, accept && cfg.busy)
    // A new result never overwrites one the master has not taken.
    `BMP24FB_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, emit, !m_tvalid || m_tready)
    // Every enabled write lands inside the framebuffer.
    `BMP24FB_ASSERT_IMPLY(a_addr_in_range, clk, rst_n, m_tvalid && m_tuser, addr_in_range)

endmodule

`default_nettype wire

[src/bmp24fb_cfg.sv]
// Configuration registers, operand clamping and the short pipeline that
// derives the walker's restart values. Depends on bmp24fb_pkg.
`default_nettype none

module bmp24fb_cfg #(
    parameter int SCREEN_WIDTH   = 800,
    parameter int MAX_IMAGE_SIDE = 4095
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [11:0]                 cfg_wdata,
    output bmp24fb_pkg::bmp24fb_cfg_t        cfg
);
    import bmp24fb_pkg::*;

    localparam int RST_HM1  = side_clamp(RST_IMAGE_HEIGHT, MAX_IMAGE_SIDE) - 1;
    localparam int RST_Q    = RST_HM1 / RST_REDUCE_STEP;
    localparam int RST_PH   = RST_HM1 % RST_REDUCE_STEP;
    localparam int RST_SR   = RST_Y_OFFSET + RST_Q;
    localparam int RST_BASE = (RST_SR * SCREEN_WIDTH) % (1 << ADDR_W);
    localparam int PROD_W   = COORD_W + 13;

    logic [SIDE_W-1:0]  width_reg, width_next;
    logic [SIDE_W-1:0]  height_reg, height_next;
    logic [XOFF_W-1:0]  xoff_reg, xoff_next;
    logic [YOFF_W-1:0]  yoff_reg, yoff_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               write_hit;

    logic [SIDE_W-1:0]  eff_width;
    logic [SIDE_W-1:0]  eff_height;
    logic [STEP_W-1:0]  eff_step;

    logic [SIDE_W-1:0]  hm1_reg, hm1_next;
    logic [SIDE_W-1:0]  q_reg, q_next;
    logic [SIDE_W-1:0]  q_div3;
    logic [1:0]         rphase_reg, rphase_next;
    logic [COORD_W-1:0] sr_init_reg, sr_init_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [2:0]         pend_reg, pend_next;

    // Register write decode.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        xoff_next   = xoff_reg;
        yoff_next   = yoff_reg;
        step_next   = step_reg;
        write_hit   = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    width_next = cfg_wdata;
                    write_hit  = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_wdata;
                    write_hit   = 1'b1;
                end
                REG_X_OFFSET:
                begin
                    xoff_next = cfg_wdata[XOFF_W-1:0];
                    write_hit = 1'b1;
                end
                REG_Y_OFFSET:
                begin
                    yoff_next = cfg_wdata[YOFF_W-1:0];
                    write_hit = 1'b1;
                end
                REG_REDUCE_STEP:
                begin
                    step_next = cfg_wdata[STEP_W-1:0];
                    write_hit = 1'b1;
                end
                default:
                begin
                    write_hit = 1'b0;
                end
            endcase
        end
    end

    // Clamp the sides and the step to their usable ranges.
    always_comb
    begin
        eff_width = width_reg;
        if (width_reg == '0)
            eff_width = SIDE_W'(1);
        else if (32'(width_reg) > 32'(MAX_IMAGE_SIDE))
            eff_width = SIDE_W'(MAX_IMAGE_SIDE);

        eff_height = height_reg;
        if (height_reg == '0)
            eff_height = SIDE_W'(1);
        else if (32'(height_reg) > 32'(MAX_IMAGE_SIDE))
            eff_height = SIDE_W'(MAX_IMAGE_SIDE);

        eff_step = step_reg;
        if (step_reg < STEP_MIN)
            eff_step = STEP_MIN;
        else if (step_reg > STEP_MAX)
            eff_step = STEP_MAX;
    end

    // Restart values: top row index, then its quotient by the step, then the
    // remainder and screen row, then the row's framebuffer base address.
    assign q_div3 = SIDE_W'((2 * SIDE_W)'(hm1_reg) * (2 * SIDE_W)'(DIV3_MUL) >> DIV3_SHIFT);

    always_comb
    begin
        hm1_next = SIDE_W'(eff_height - SIDE_W'(1));
        case (eff_step)
            3'd1:    q_next = hm1_reg;
            3'd2:    q_next = hm1_reg >> 1;
            3'd3:    q_next = q_div3;
            default: q_next = hm1_reg >> 2;
        endcase
        rphase_next  = 2'(hm1_reg - SIDE_W'(q_reg * SIDE_W'(eff_step)));
        sr_init_next = COORD_W'(yoff_reg) + COORD_W'(q_reg);
        base_next    = ADDR_W'(PROD_W'(sr_init_reg) * PROD_W'(SCREEN_WIDTH));
        pend_next    = write_hit ? PEND_CYCLES :
                       (pend_reg != '0) ? 3'(pend_reg - 3'd1) : pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= SIDE_W'(RST_IMAGE_WIDTH);
            height_reg  <= SIDE_W'(RST_IMAGE_HEIGHT);
            xoff_reg    <= XOFF_W'(RST_X_OFFSET);
            yoff_reg    <= YOFF_W'(RST_Y_OFFSET);
            step_reg    <= STEP_W'(RST_REDUCE_STEP);
            hm1_reg     <= SIDE_W'(RST_HM1);
            q_reg       <= SIDE_W'(RST_Q);
            rphase_reg  <= 2'(RST_PH);
            sr_init_reg <= COORD_W'(RST_SR);
            base_reg    <= ADDR_W'(RST_BASE);
            pend_reg    <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            xoff_reg    <= xoff_next;
            yoff_reg    <= yoff_next;
            step_reg    <= step_next;
            hm1_reg     <= hm1_next;
            q_reg       <= q_next;
            rphase_reg  <= rphase_next;
            sr_init_reg <= sr_init_next;
            base_reg    <= base_next;
            pend_reg    <= pend_next;
        end
    end

    // Effective values toward the walker.
    always_comb
    begin
        cfg.busy            = (pend_reg != '0);
        cfg.restart         = (pend_reg == 3'd1);
        cfg.width           = eff_width;
        cfg.step            = eff_step;
        cfg.x_offset        = xoff_reg;
        cfg.init_row_count  = hm1_reg;
        cfg.init_row_phase  = rphase_reg;
        cfg.init_screen_row = sr_init_reg;
        cfg.init_row_base   = base_reg;
    end

endmodule

`default_nettype wire

[src/bmp24fb_walker.sv]
// Pixel walker: byte assembly, row padding skip, decimation phases and
// screen position tracking for one accepted input byte per cycle. Depends on bmp24fb_pkg.
`default_nettype none

module bmp24fb_walker #(
    parameter int SCREEN_WIDTH   = 800,
    parameter int SCREEN_HEIGHT  = 480,
    parameter int MAX_IMAGE_SIDE = 4095
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bmp24fb_pkg::bmp24fb_cfg_t     cfg,
    input  wire logic                          accept,
    input  wire logic [7:0]                    data_byte,
    output logic                               will_emit,
    output bmp24fb_pkg::bmp24fb_result_t       result
);
    import bmp24fb_pkg::*;

    localparam int RST_HM1  = side_clamp(RST_IMAGE_HEIGHT, MAX_IMAGE_SIDE) - 1;
    localparam int RST_Q    = RST_HM1 / RST_REDUCE_STEP;
    localparam int RST_PH   = RST_HM1 % RST_REDUCE_STEP;
    localparam int RST_SR   = RST_Y_OFFSET + RST_Q;
    localparam int RST_BASE = (RST_SR * SCREEN_WIDTH) % (1 << ADDR_W);

    byte_phase_t        byte_phase_reg, byte_phase_next;
    logic [7:0]         blue_reg, blue_next;
    logic [7:0]         green_reg, green_next;
    logic [SIDE_W-1:0]  col_count_reg, col_count_next;
    logic [SIDE_W-1:0]  row_count_reg, row_count_next;
    logic [1:0]         pad_reg, pad_next;
    logic [1:0]         col_phase_reg, col_phase_next;
    logic [1:0]         row_phase_reg, row_phase_next;
    logic [COORD_W-1:0] sc_reg, sc_next;
    logic [COORD_W-1:0] sr_reg, sr_next;
    logic [ADDR_W-1:0]  base_reg, base_next;

    logic [1:0]         step_m1;
    logic               keep;
    logic               end_row_req;
    logic               reinit;

    assign step_m1 = 2'(cfg.step - STEP_MIN);

    // A transaction produces a result on a red byte and on the image's last pad byte.
    assign will_emit = (pad_reg != '0) ? (pad_reg == 2'd1 && row_count_reg == '0)
                                       : (byte_phase_reg != BP_BLUE &&
                                          byte_phase_reg != BP_GREEN);

    // The pixel is written only on phase zero in both directions and on screen.
    assign keep = (col_phase_reg == '0) && (row_phase_reg == '0) &&
                  (sc_reg < COORD_W'(SCREEN_WIDTH)) && (sr_reg < COORD_W'(SCREEN_HEIGHT));

    // Next state and result for the accepted byte.
    always_comb
    begin
        byte_phase_next = byte_phase_reg;
        blue_next       = blue_reg;
        green_next      = green_reg;
        col_count_next  = col_count_reg;
        row_count_next  = row_count_reg;
        pad_next        = pad_reg;
        col_phase_next  = col_phase_reg;
        row_phase_next  = row_phase_reg;
        sc_next         = sc_reg;
        sr_next         = sr_reg;
        base_next       = base_reg;
        end_row_req     = 1'b0;
        result          = '0;

        if (accept)
        begin
            if (pad_reg != '0)
            begin
                // Padding byte: skip it, the last one closes the row.
                pad_next    = 2'(pad_reg - 2'd1);
                end_row_req = (pad_reg == 2'd1);
            end
            else
            begin
                case (byte_phase_reg)
                    BP_BLUE:
                    begin
                        blue_next       = data_byte;
                        byte_phase_next = BP_GREEN;
                    end
                    BP_GREEN:
                    begin
                        green_next      = data_byte;
                        byte_phase_next = BP_RED;
                    end
                    default:
                    begin
                        // Red byte completes the pixel.
                        byte_phase_next      = BP_BLUE;
                        result.write_enable  = keep;
                        result.write_address = keep ? ADDR_W'(base_reg + ADDR_W'(sc_reg)) : '0;
                        result.pixel_word    = {data_byte, green_reg, blue_reg};
                        if (col_count_reg >= SIDE_W'(cfg.width - SIDE_W'(1)))
                        begin
                            col_count_next = '0;
                            col_phase_next = '0;
                            sc_next        = COORD_W'(cfg.x_offset);
                            pad_next       = cfg.width[1:0];
                            end_row_req    = (cfg.width[1:0] == 2'd0);
                        end
                        else
                        begin
                            col_count_next = SIDE_W'(col_count_reg + SIDE_W'(1));
                            if (col_phase_reg == step_m1)
                            begin
                                col_phase_next = '0;
                                sc_next        = COORD_W'(sc_reg + COORD_W'(1));
                            end
                            else
                            begin
                                col_phase_next = 2'(col_phase_reg + 2'd1);
                            end
                        end
                    end
                endcase
            end

            // Row change: count down the rows and, on row phase zero, move one row up the screen, or finish the image.
            if (end_row_req)
            begin
                if (row_count_reg == '0)
                begin
                    result.image_done = 1'b1;
                end
                else
                begin
                    row_count_next = SIDE_W'(row_count_reg - SIDE_W'(1));
                    if (row_phase_reg == '0)
                    begin
                        row_phase_next = step_m1;
                        sr_next        = COORD_W'(sr_reg - COORD_W'(1));
                        base_next      = ADDR_W'(base_reg - ADDR_W'(SCREEN_WIDTH));
                    end
                    else
                    begin
                        row_phase_next = 2'(row_phase_reg - 2'd1);
                    end
                end
            end
        end

        // Reload for a register write or after the image's last byte.
        reinit = cfg.restart || (accept && end_row_req && row_count_reg == '0);
        if (reinit)
        begin
            byte_phase_next = BP_BLUE;
            blue_next       = '0;
            green_next      = '0;
            col_count_next  = '0;
            pad_next        = '0;
            col_phase_next  = '0;
            sc_next         = COORD_W'(cfg.x_offset);
            row_count_next  = cfg.init_row_count;
            row_phase_next  = cfg.init_row_phase;
            sr_next         = cfg.init_screen_row;
            base_next       = cfg.init_row_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_phase_reg <= BP_BLUE;
            blue_reg       <= '0;
            green_reg      <= '0;
            col_count_reg  <= '0;
            row_count_reg  <= SIDE_W'(RST_HM1);
            pad_reg        <= '0;
            col_phase_reg  <= '0;
            row_phase_reg  <= 2'(RST_PH);
            sc_reg         <= COORD_W'(RST_X_OFFSET);
            sr_reg         <= COORD_W'(RST_SR);
            base_reg       <= ADDR_W'(RST_BASE);
        end
        else
        begin
            byte_phase_reg <= byte_phase_next;
            blue_reg       <= blue_next;
            green_reg      <= green_next;
            col_count_reg  <= col_count_next;
            row_count_reg  <= row_count_next;
            pad_reg        <= pad_next;
            col_phase_reg  <= col_phase_next;
            row_phase_reg  <= row_phase_next;
            sc_reg         <= sc_next;
            sr_reg         <= sr_next;
            base_reg       <= base_next;
        end
    end

endmodule

`default_nettype wire

[src/bmp24fb_out_reg.sv]
// Output register holding one result transaction for the master side.
// Depends on bmp24fb_pkg.
`default_nettype none

module bmp24fb_out_reg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire bmp24fb_pkg::bmp24fb_result_t  result,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic                               space,
    output bmp24fb_pkg::bmp24fb_result_t       held
);
    import bmp24fb_pkg::*;

    logic            valid_reg, valid_next;
    bmp24fb_result_t data_reg, data_next;

    // The slot is free when empty or being emptied in this cycle.
    assign space = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = result;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign held     = data_reg;

endmodule

`default_nettype wire
